@@ design/lruul_pkg.sv @@
// ----------------------------------------------------------------------------
// lruul_pkg
// Shared sizes, link encoding and operation/status codes for the LRU lists.
// ----------------------------------------------------------------------------
package lruul_pkg;

    localparam int ENTRIES = 1024;
    localparam int IDX_W   = 10;
    localparam int LINK_W  = IDX_W + 1;
    localparam int USERS   = 4;
    localparam int USER_W  = 2;

    // null link: entry count, i.e. only the top bit set
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(ENTRIES);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_HIT    = 2'd1,
        MODE_EVICT  = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_HIT_MISS   = 2'd1,
        ST_EVICT_EMPTY = 2'd2,
        ST_INS_DUP    = 2'd3
    } status_t;

endpackage

@@ design/lruul_ram.sv @@
// ----------------------------------------------------------------------------
// lruul_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lruul_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/lru_replacement_with_user_lists_core.sv @@
// ----------------------------------------------------------------------------
// lru_replacement_with_user_lists_core
// Global LRU list plus one LRU sub-list per user over cache entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_tvalid/s_tready/s_tdata) carries one command item:
//   insert an entry for a user, hit on an entry, or evict the least recent
//   entry of a user. Output stream (m_tvalid/m_tready/m_tdata) returns one
//   result item per command: a status code and, for a good evict, the index.
//   Links live in five link/owner RAMs plus a resident-bit RAM, all with a
//   registered read port. A command is read in its accept cycle, then
//   unlinked in S_EXEC, then relinked at the heads in S_LINK1 and S_LINK2
//   (both prev writes hit the same prev RAM port).
//   Insert and hit pass through S_EXEC, S_LINK1 and S_LINK2 before the
//   result is registered; evict and error cases register it from S_EXEC.
//   One command is in flight at a time; the next is taken once the block
//   is idle and the result register is free or being drained that same
//   cycle.
//   Reset: heads/tails go null, then a pass over every entry clears the
//   resident RAM; s_tready stays low during that pass.
//   A stalled m_tready simply holds the result; a new command is then
//   refused until the result is taken.
// ----------------------------------------------------------------------------
module lru_replacement_with_user_lists_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] mode, [11:2] entry_index, [13:12] user_id
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [1:0] status, [11:2] evicted_index
);

    localparam int IW = lruul_pkg::IDX_W;
    localparam int LW = lruul_pkg::LINK_W;
    localparam int UW = lruul_pkg::USER_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_LINK1,
        S_LINK2
    } state_t;

    state_t            state_reg;
    logic [IW-1:0]     clr_cnt_reg;
    lruul_pkg::mode_t  mode_reg;
    logic [IW-1:0]     tgt_reg;
    logic [UW-1:0]     user_reg;
    logic              empty_reg;
    logic [UW-1:0]     lusr_reg;
    logic [LW-1:0]     ghead_reg;
    logic [LW-1:0]     gtail_reg;
    logic [LW-1:0]     uhead_reg [lruul_pkg::USERS];
    logic [LW-1:0]     utail_reg [lruul_pkg::USERS];
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic [IW-1:0]     evicted_reg;

    // input fields
    lruul_pkg::mode_t  in_mode;
    logic [IW-1:0]     in_entry;
    logic [UW-1:0]     in_user;
    logic              accept;
    logic [IW-1:0]     raddr;

    assign in_mode  = lruul_pkg::mode_t'(s_tdata[1:0]);
    assign in_entry = s_tdata[11:2];
    assign in_user  = s_tdata[13:12];

    assign s_tready = (state_reg == S_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign raddr    = (in_mode == lruul_pkg::MODE_EVICT) ? utail_reg[in_user][IW-1:0]
                                                         : in_entry;

    // RAM ports
    logic          gp_we, gn_we, op_we, on_we, ow_we, rs_we;
    logic [IW-1:0] gp_wa, gn_wa, op_wa, on_wa, ow_wa, rs_wa;
    logic [LW-1:0] gp_wd, gn_wd, op_wd, on_wd;
    logic [UW-1:0] ow_wd;
    logic          rs_wd;
    logic [LW-1:0] gp_rd, gn_rd, op_rd, on_rd;
    logic [UW-1:0] ow_rd;
    logic          rs_rd;

    lruul_ram #(.WIDTH(LW), .DEPTH(lruul_pkg::ENTRIES)) u_gprev (
        .clk(clk), .we(gp_we), .waddr(gp_wa), .wdata(gp_wd), .raddr(raddr), .rdata(gp_rd));
    lruul_ram #(.WIDTH(LW), .DEPTH(lruul_pkg::ENTRIES)) u_gnext (
        .clk(clk), .we(gn_we), .waddr(gn_wa), .wdata(gn_wd), .raddr(raddr), .rdata(gn_rd));
    lruul_ram #(.WIDTH(LW), .DEPTH(lruul_pkg::ENTRIES)) u_oprev (
        .clk(clk), .we(op_we), .waddr(op_wa), .wdata(op_wd), .raddr(raddr), .rdata(op_rd));
    lruul_ram #(.WIDTH(LW), .DEPTH(lruul_pkg::ENTRIES)) u_onext (
        .clk(clk), .we(on_we), .waddr(on_wa), .wdata(on_wd), .raddr(raddr), .rdata(on_rd));
    lruul_ram #(.WIDTH(UW), .DEPTH(lruul_pkg::ENTRIES)) u_owner (
        .clk(clk), .we(ow_we), .waddr(ow_wa), .wdata(ow_wd), .raddr(raddr), .rdata(ow_rd));
    lruul_ram #(.WIDTH(1), .DEPTH(lruul_pkg::ENTRIES)) u_resident (
        .clk(clk), .we(rs_we), .waddr(rs_wa), .wdata(rs_wd), .raddr(raddr), .rdata(rs_rd));

    // decisions made in the execute cycle
    logic do_unlink;
    logic do_link;
    logic [LW-1:0] uhead_l, tgt_link;

    assign tgt_link = {1'b0, tgt_reg};
    assign uhead_l  = uhead_reg[lusr_reg];

    always_comb
    begin
        do_unlink = 1'b0;
        do_link   = 1'b0;
        case (mode_reg)
            lruul_pkg::MODE_INSERT: do_link   = !rs_rd;
            lruul_pkg::MODE_HIT:
            begin
                do_unlink = rs_rd;
                do_link   = rs_rd;
            end
            lruul_pkg::MODE_EVICT:  do_unlink = !empty_reg;
            default:                do_unlink = 1'b0;
        endcase
    end

    // memory write steering
    always_comb
    begin
        gp_we = 1'b0; gp_wa = tgt_reg; gp_wd = lruul_pkg::LINK_NULL;
        gn_we = 1'b0; gn_wa = tgt_reg; gn_wd = lruul_pkg::LINK_NULL;
        op_we = 1'b0; op_wa = tgt_reg; op_wd = lruul_pkg::LINK_NULL;
        on_we = 1'b0; on_wa = tgt_reg; on_wd = lruul_pkg::LINK_NULL;
        ow_we = 1'b0; ow_wa = tgt_reg; ow_wd = user_reg;
        rs_we = 1'b0; rs_wa = tgt_reg; rs_wd = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                rs_we = 1'b1;
                rs_wa = clr_cnt_reg;
            end
            S_EXEC:
            begin
                if (do_unlink)
                begin
                    gn_we = !gp_rd[LW-1]; gn_wa = gp_rd[IW-1:0]; gn_wd = gn_rd;
                    gp_we = !gn_rd[LW-1]; gp_wa = gn_rd[IW-1:0]; gp_wd = gp_rd;
                    on_we = !op_rd[LW-1]; on_wa = op_rd[IW-1:0]; on_wd = on_rd;
                    op_we = !on_rd[LW-1]; op_wa = on_rd[IW-1:0]; op_wd = op_rd;
                end
                if (mode_reg == lruul_pkg::MODE_INSERT && !rs_rd)
                begin
                    ow_we = 1'b1;
                    rs_we = 1'b1;
                    rs_wd = 1'b1;
                end
                if (mode_reg == lruul_pkg::MODE_EVICT && !empty_reg)
                begin
                    rs_we = 1'b1;
                end
            end
            S_LINK1:
            begin
                gn_we = 1'b1; gn_wd = ghead_reg;
                on_we = 1'b1; on_wd = uhead_l;
                gp_we = !ghead_reg[LW-1]; gp_wa = ghead_reg[IW-1:0]; gp_wd = tgt_link;
                op_we = !uhead_l[LW-1];   op_wa = uhead_l[IW-1:0];   op_wd = tgt_link;
            end
            S_LINK2:
            begin
                gp_we = 1'b1;
                op_we = 1'b1;
            end
            default:
            begin
                gp_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            ghead_reg     <= lruul_pkg::LINK_NULL;
            gtail_reg     <= lruul_pkg::LINK_NULL;
            for (int i = 0; i < lruul_pkg::USERS; i++)
            begin
                uhead_reg[i] <= lruul_pkg::LINK_NULL;
                utail_reg[i] <= lruul_pkg::LINK_NULL;
            end
            out_valid_reg <= 1'b0;
            status_reg    <= '0;
            evicted_reg   <= '0;
            mode_reg      <= lruul_pkg::MODE_NONE;
            tgt_reg       <= '0;
            user_reg      <= '0;
            empty_reg     <= 1'b0;
            lusr_reg      <= '0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (&clr_cnt_reg)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        mode_reg  <= in_mode;
                        tgt_reg   <= raddr;
                        user_reg  <= in_user;
                        empty_reg <= utail_reg[in_user][LW-1];
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    lusr_reg <= (mode_reg == lruul_pkg::MODE_INSERT) ? user_reg : ow_rd;
                    if (do_unlink)
                    begin
                        if (gp_rd[LW-1]) ghead_reg <= gn_rd;
                        if (gn_rd[LW-1]) gtail_reg <= gp_rd;
                        if (op_rd[LW-1]) uhead_reg[ow_rd] <= on_rd;
                        if (on_rd[LW-1]) utail_reg[ow_rd] <= op_rd;
                    end
                    if (do_link)
                    begin
                        state_reg <= S_LINK1;
                    end
                    else
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                        case (mode_reg)
                            lruul_pkg::MODE_INSERT:
                            begin
                                status_reg  <= lruul_pkg::ST_INS_DUP;
                                evicted_reg <= '0;
                            end
                            lruul_pkg::MODE_HIT:
                            begin
                                status_reg  <= lruul_pkg::ST_HIT_MISS;
                                evicted_reg <= '0;
                            end
                            lruul_pkg::MODE_EVICT:
                            begin
                                status_reg  <= empty_reg ? lruul_pkg::ST_EVICT_EMPTY
                                                         : lruul_pkg::ST_DONE;
                                evicted_reg <= empty_reg ? '0 : tgt_reg;
                            end
                            default:
                            begin
                                status_reg  <= lruul_pkg::ST_DONE;
                                evicted_reg <= '0;
                            end
                        endcase
                    end
                end
                S_LINK1:
                begin
                    if (ghead_reg[LW-1]) gtail_reg <= tgt_link;
                    ghead_reg <= tgt_link;
                    if (uhead_l[LW-1]) utail_reg[lusr_reg] <= tgt_link;
                    uhead_reg[lusr_reg] <= tgt_link;
                    state_reg <= S_LINK2;
                end
                S_LINK2:
                begin
                    state_reg     <= S_IDLE;
                    out_valid_reg <= 1'b1;
                    status_reg    <= lruul_pkg::ST_DONE;
                    evicted_reg   <= '0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, evicted_reg, status_reg};

endmodule

@@ tb/lru_replacement_with_user_lists_checker.sv @@
// ----------------------------------------------------------------------------
// lru_replacement_with_user_lists_checker
// Watches the command and result streams, keeps its own copy of the global
// and per-user LRU lists, and compares every result item in order.
// ----------------------------------------------------------------------------
module lru_replacement_with_user_lists_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        lruul_pkg::status_t          status;
        logic [lruul_pkg::IDX_W-1:0] evicted;
    } lru_result_t;

    logic [lruul_pkg::LINK_W-1:0] g_prev [lruul_pkg::ENTRIES];
    logic [lruul_pkg::LINK_W-1:0] g_next [lruul_pkg::ENTRIES];
    logic [lruul_pkg::LINK_W-1:0] o_prev [lruul_pkg::ENTRIES];
    logic [lruul_pkg::LINK_W-1:0] o_next [lruul_pkg::ENTRIES];
    logic [lruul_pkg::USER_W-1:0] owner  [lruul_pkg::ENTRIES];
    logic                         res    [lruul_pkg::ENTRIES];
    logic [lruul_pkg::LINK_W-1:0] g_head, g_tail;
    logic [lruul_pkg::LINK_W-1:0] u_head [lruul_pkg::USERS];
    logic [lruul_pkg::LINK_W-1:0] u_tail [lruul_pkg::USERS];

    lru_result_t expected_results [$];

    function automatic bit is_link(logic [lruul_pkg::LINK_W-1:0] l);
        return l != lruul_pkg::LINK_NULL;
    endfunction

    task automatic detach(logic [lruul_pkg::IDX_W-1:0] e);
        logic [lruul_pkg::USER_W-1:0] u;
        logic [lruul_pkg::LINK_W-1:0] p, n;
        u = owner[e];
        p = g_prev[e];
        n = g_next[e];
        if (is_link(p)) g_next[p[lruul_pkg::IDX_W-1:0]] = n; else g_head = n;
        if (is_link(n)) g_prev[n[lruul_pkg::IDX_W-1:0]] = p; else g_tail = p;
        p = o_prev[e];
        n = o_next[e];
        if (is_link(p)) o_next[p[lruul_pkg::IDX_W-1:0]] = n; else u_head[u] = n;
        if (is_link(n)) o_prev[n[lruul_pkg::IDX_W-1:0]] = p; else u_tail[u] = p;
        g_prev[e] = lruul_pkg::LINK_NULL;
        g_next[e] = lruul_pkg::LINK_NULL;
        o_prev[e] = lruul_pkg::LINK_NULL;
        o_next[e] = lruul_pkg::LINK_NULL;
    endtask

    task automatic push_front(logic [lruul_pkg::IDX_W-1:0] e);
        logic [lruul_pkg::USER_W-1:0] u;
        logic [lruul_pkg::LINK_W-1:0] h;
        u = owner[e];
        h = g_head;
        g_prev[e] = lruul_pkg::LINK_NULL;
        g_next[e] = h;
        if (is_link(h)) g_prev[h[lruul_pkg::IDX_W-1:0]] = {1'b0, e}; else g_tail = {1'b0, e};
        g_head = {1'b0, e};
        h = u_head[u];
        o_prev[e] = lruul_pkg::LINK_NULL;
        o_next[e] = h;
        if (is_link(h)) o_prev[h[lruul_pkg::IDX_W-1:0]] = {1'b0, e}; else u_tail[u] = {1'b0, e};
        u_head[u] = {1'b0, e};
    endtask

    // Apply one command to the model lists and return the result it yields.
    task automatic apply_command(logic [15:0] cmd, output lru_result_t r);
        lruul_pkg::mode_t             mode;
        logic [lruul_pkg::IDX_W-1:0]  e;
        logic [lruul_pkg::USER_W-1:0] u;
        logic [lruul_pkg::LINK_W-1:0] t;
        mode = lruul_pkg::mode_t'(cmd[1:0]);
        e    = cmd[11:2];
        u    = cmd[13:12];
        r.status  = lruul_pkg::ST_DONE;
        r.evicted = '0;
        case (mode)
            lruul_pkg::MODE_INSERT:
                if (res[e]) r.status = lruul_pkg::ST_INS_DUP;
                else
                begin
                    owner[e] = u;
                    res[e]   = 1'b1;
                    push_front(e);
                end
            lruul_pkg::MODE_HIT:
                if (!res[e]) r.status = lruul_pkg::ST_HIT_MISS;
                else
                begin
                    detach(e);
                    push_front(e);
                end
            lruul_pkg::MODE_EVICT:
            begin
                t = u_tail[u];
                if (!is_link(t)) r.status = lruul_pkg::ST_EVICT_EMPTY;
                else
                begin
                    detach(t[lruul_pkg::IDX_W-1:0]);
                    res[t[lruul_pkg::IDX_W-1:0]] = 1'b0;
                    r.evicted = t[lruul_pkg::IDX_W-1:0];
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        lru_result_t exp_r, got_r;
        if (!rst_n)
        begin
            for (int i = 0; i < lruul_pkg::ENTRIES; i++)
            begin
                g_prev[i] = lruul_pkg::LINK_NULL;
                g_next[i] = lruul_pkg::LINK_NULL;
                o_prev[i] = lruul_pkg::LINK_NULL;
                o_next[i] = lruul_pkg::LINK_NULL;
                owner[i]  = '0;
                res[i]    = 1'b0;
            end
            g_head = lruul_pkg::LINK_NULL;
            g_tail = lruul_pkg::LINK_NULL;
            for (int i = 0; i < lruul_pkg::USERS; i++)
            begin
                u_head[i] = lruul_pkg::LINK_NULL;
                u_tail[i] = lruul_pkg::LINK_NULL;
            end
            expected_results.delete();
            fail_count    = 0;
            pending_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                apply_command(s_tdata, exp_r);
                expected_results.push_back(exp_r);
            end
            if (m_tvalid && m_tready)
            begin
                got_r.status  = lruul_pkg::status_t'(m_tdata[1:0]);
                got_r.evicted = m_tdata[11:2];
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result item: status %0d index %0d",
                                 got_r.status, got_r.evicted);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (got_r.status !== exp_r.status || got_r.evicted !== exp_r.evicted)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp status %0d index %0d, %s %0d index %0d",
                                     exp_r.status, exp_r.evicted, "got status",
                                     got_r.status, got_r.evicted);
                    end
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

@@ tb/lru_replacement_with_user_lists_core_tb.sv @@
// ----------------------------------------------------------------------------
// lru_replacement_with_user_lists_core_tb
// Drives insert, hit, evict and unused-mode commands into the LRU list block with random
// gaps and output stalls; a checker alongside predicts and compares results.
// ----------------------------------------------------------------------------
module lru_replacement_with_user_lists_core_tb;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // [1:0] mode, [11:2] entry_index, [13:12] user_id
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [1:0] status, [11:2] evicted_index

    int fail_count;
    int pending_count;
    int cycle_count;

    // Cycle budget: the reset clear plus 1820 items, each with its random gap and output stall.
    localparam int CYCLE_LIMIT = 400000;

    // Tracks entries that have been inserted, so random hits stay mostly
    // meaningful; the checker is the sole judge of correctness.
    logic [lruul_pkg::IDX_W-1:0] live_entries [$];

    lru_replacement_with_user_lists_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    lru_replacement_with_user_lists_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle watchdog
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Output side: random stalls per item, with quiet stretches of none.
    initial
    begin
        int stall;
        bit quiet;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            quiet = ($urandom_range(0, 3) == 0);
            repeat (40)
            begin
                stall = quiet ? 0 : $urandom_range(0, 15);
                repeat (stall)
                begin
                    @(posedge clk);
                    m_tready <= 1'b0;
                end
                @(posedge clk);
                m_tready <= 1'b1;
                do @(posedge clk); while (!(m_tvalid && m_tready));
                m_tready <= 1'b0;
            end
        end
    end

    // Send one command; valid drops only during an idle gap.
    task automatic send_cmd(lruul_pkg::mode_t mode, logic [lruul_pkg::IDX_W-1:0] e,
                            logic [lruul_pkg::USER_W-1:0] u, int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata  <= {2'b00, u, e, mode};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!(s_tvalid && s_tready));
    endtask

    task automatic note_cmd(lruul_pkg::mode_t mode, logic [lruul_pkg::IDX_W-1:0] e);
        if (mode == lruul_pkg::MODE_INSERT)
        begin
            foreach (live_entries[i])
                if (live_entries[i] == e) return;
            live_entries.push_back(e);
        end
    endtask

    initial
    begin
        lruul_pkg::mode_t             mode;
        logic [lruul_pkg::IDX_W-1:0]  e;
        logic [lruul_pkg::USER_W-1:0] u;
        int                           gap;
        int                           pick;
        bit                           quiet;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty evicts, misses, extremes, single-entry lists,
        // duplicate insert, hit from a foreign user, unused mode.
        send_cmd(lruul_pkg::MODE_EVICT,  10'd0,    2'd0, 0);
        send_cmd(lruul_pkg::MODE_EVICT,  10'd0,    2'd3, 0);
        send_cmd(lruul_pkg::MODE_HIT,    10'd1023, 2'd0, 0);
        send_cmd(lruul_pkg::MODE_INSERT, 10'd0,    2'd0, 0);
        send_cmd(lruul_pkg::MODE_INSERT, 10'd0,    2'd1, 0);
        send_cmd(lruul_pkg::MODE_HIT,    10'd0,    2'd3, 1);
        send_cmd(lruul_pkg::MODE_EVICT,  10'd0,    2'd0, 0);
        send_cmd(lruul_pkg::MODE_EVICT,  10'd0,    2'd0, 0);
        send_cmd(lruul_pkg::MODE_INSERT, 10'd1023, 2'd3, 0);
        send_cmd(lruul_pkg::MODE_INSERT, 10'd512,  2'd3, 0);
        send_cmd(lruul_pkg::MODE_INSERT, 10'd341,  2'd2, 2);
        send_cmd(lruul_pkg::MODE_INSERT, 10'd682,  2'd1, 0);
        send_cmd(lruul_pkg::MODE_HIT,    10'd1023, 2'd0, 0);
        send_cmd(lruul_pkg::MODE_NONE,   10'd1023, 2'd3, 0);
        send_cmd(lruul_pkg::MODE_NONE,   10'd0,    2'd0, 0);
        send_cmd(lruul_pkg::MODE_EVICT,  10'd1023, 2'd3, 0);
        send_cmd(lruul_pkg::MODE_EVICT,  10'd0,    2'd3, 0);
        send_cmd(lruul_pkg::MODE_EVICT,  10'd0,    2'd3, 0);
        send_cmd(lruul_pkg::MODE_EVICT,  10'd0,    2'd2, 3);
        send_cmd(lruul_pkg::MODE_EVICT,  10'd0,    2'd1, 0);

        // Random: mostly inserts/hits on a small working set so lists grow
        // and shrink; evicts return entries to the pool.
        for (int blk = 0; blk < 45; blk++)
        begin
            quiet = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 40; k++)
            begin
                gap  = quiet ? 0 : $urandom_range(0, 15);
                pick = $urandom_range(0, 99);
                u    = lruul_pkg::USER_W'($urandom_range(0, lruul_pkg::USERS - 1));
                if (pick < 35)
                begin
                    mode = lruul_pkg::MODE_INSERT;
                    e = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                                    : 10'($urandom_range(0, 47));
                end
                else if (pick < 65)
                begin
                    mode = lruul_pkg::MODE_HIT;
                    e = (live_entries.size() > 0 && $urandom_range(0, 5) != 0)
                        ? live_entries[$urandom_range(0, live_entries.size() - 1)]
                        : 10'($urandom);
                end
                else if (pick < 97)
                begin
                    mode = lruul_pkg::MODE_EVICT;
                    e = 10'($urandom);
                end
                else
                begin
                    mode = lruul_pkg::MODE_NONE;
                    e = 10'($urandom);
                end
                note_cmd(mode, e);
                send_cmd(mode, e, u, gap);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_count != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
